FILE: design/klex_pkg.sv
package klex_pkg;

    // Default depth of the stored word prefix used for keyword matching
    localparam int KEYWORD_MAX_DEF = 6;

    // Longest supported line, in bytes
    localparam int LINE_LEN = 4096;

    // Saturation limits
    localparam logic [11:0] COL_CAP  = (LINE_LEN - 1 > 4095) ? 12'd4095 : 12'(LINE_LEN - 1);
    localparam logic [11:0] LEN_CAP  = 12'd4095;
    localparam logic [15:0] LINE_CAP = 16'd65535;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Token kinds
    localparam logic [3:0] KIND_WORD   = 4'd0;
    localparam logic [3:0] KIND_SEMI   = 4'd1;
    localparam logic [3:0] KIND_LPAREN = 4'd2;
    localparam logic [3:0] KIND_RPAREN = 4'd3;
    localparam logic [3:0] KIND_LBRACE = 4'd4;
    localparam logic [3:0] KIND_RBRACE = 4'd5;
    localparam logic [3:0] KIND_PLUS   = 4'd6;
    localparam logic [3:0] KIND_MINUS  = 4'd7;
    localparam logic [3:0] KIND_SLASH  = 4'd8;
    localparam logic [3:0] KIND_STAR   = 4'd9;
    localparam logic [3:0] KIND_EQUAL  = 4'd10;
    localparam logic [3:0] KIND_QUOTE  = 4'd11;
    localparam logic [3:0] KIND_COMMA  = 4'd12;
    localparam logic [3:0] KIND_RETURN = 4'd13;
    localparam logic [3:0] KIND_IF     = 4'd14;
    localparam logic [3:0] KIND_ELSE   = 4'd15;

    // Character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

    // Keyword spellings, first byte at index 0
    localparam logic [7:0] KW_RETURN_TEXT [6] = '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E};
    localparam logic [7:0] KW_IF_TEXT     [2] = '{8'h69, 8'h66};
    localparam logic [7:0] KW_ELSE_TEXT   [4] = '{8'h65, 8'h6C, 8'h73, 8'h65};

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] line;
        logic [11:0] start_col;
        logic [11:0] end_col;
        logic        last;
    } klex_tok_t;

    // Up to two tokens handed to the result queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        klex_tok_t  first;
        klex_tok_t  second;
    } klex_push_t;

    // Punctuation kind of a byte, KIND_WORD when it is not punctuation
    function automatic logic [3:0] punct_kind(input logic [7:0] ch);
        logic [3:0] kind;
        unique case (ch)
            CH_SEMI:   kind = KIND_SEMI;
            CH_LPAREN: kind = KIND_LPAREN;
            CH_RPAREN: kind = KIND_RPAREN;
            CH_LBRACE: kind = KIND_LBRACE;
            CH_RBRACE: kind = KIND_RBRACE;
            CH_PLUS:   kind = KIND_PLUS;
            CH_MINUS:  kind = KIND_MINUS;
            CH_SLASH:  kind = KIND_SLASH;
            CH_STAR:   kind = KIND_STAR;
            CH_EQUAL:  kind = KIND_EQUAL;
            CH_QUOTE:  kind = KIND_QUOTE;
            CH_COMMA:  kind = KIND_COMMA;
            default:   kind = KIND_WORD;
        endcase
        return kind;
    endfunction

endpackage

FILE: design/klex_if.sv
interface klex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface klex_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] line_number;
    logic [11:0] start_column;
    logic [11:0] end_column;
    logic        last;

    modport source (output valid, output token_kind, output line_number,
                    output start_column, output end_column, output last, input ready);
    modport sink   (input valid, input token_kind, input line_number,
                    input start_column, input end_column, input last, output ready);
endinterface

FILE: design/keyword_lexer_step.sv
// keyword_lexer_step: streaming lexer, one source byte per request on the chars
// channel (end_of_input set flushes an open word instead of taking a byte), and
// one token per request on the tokens channel. A character is accepted every
// cycle while the input register is free or the queue has room; it is held in
// the input register, where the lexer state is updated, and its tokens go to
// the result queue. Most characters give zero or one token; punctuation that
// closes a word gives two (word first, then punctuation with last set), and
// the tokens side drains one token a cycle while ready is high. A four-entry
// result queue absorbs these bursts, so chars stays ready as long as the queue
// has room for a full pair. Keywords (return, if, else) are matched from the
// first KEYWORD_MAX bytes of a word; columns saturate at 4095, lines at 65535.
// Reset closes any open word and restarts at line 1, column 0.
module keyword_lexer_step #(
    parameter int KEYWORD_MAX = klex_pkg::KEYWORD_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    klex_in_if.sink     chars,
    klex_out_if.source  tokens
);
    import klex_pkg::*;

    klex_push_t              push;
    logic                    room;
    logic [QUEUE_CNT_W-1:0]  level;

    // Classify the byte, update word/column/line state, hand off tokens
    klex_scan #(
        .KEYWORD_MAX (KEYWORD_MAX)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .room  (room),
        .push  (push)
    );

    // Hold tokens until the consumer takes them
    klex_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .level  (level),
        .tokens (tokens)
    );

    // A pair is always the word first, then the punctuation that closed it
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> (!push.first.last && push.second.last))
        else $error("token pair out of order");

    // Never push more than the queue can hold
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // Tokens handed to the queue are offered on the next cycle
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |=> tokens.valid)
        else $error("pushed token not offered");

endmodule

FILE: design/klex_scan.sv
module klex_scan #(
    parameter int KEYWORD_MAX = klex_pkg::KEYWORD_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    klex_in_if.sink              chars,
    input  logic                 room,
    output klex_pkg::klex_push_t push
);
    import klex_pkg::*;

    localparam int KW_IDX_W = $clog2(KEYWORD_MAX);

    // Input register
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] ch_reg;
    logic       eoi_reg;

    // Lexer state
    logic        in_word_reg, in_word_next;
    logic [11:0] word_start_reg, word_start_next;
    logic [11:0] word_len_reg, word_len_next;
    logic [7:0]  kw_bytes_reg [KEYWORD_MAX];
    logic [7:0]  kw_bytes_next [KEYWORD_MAX];
    logic [11:0] column_reg, column_next;
    logic [15:0] line_reg, line_next;

    logic        accept;
    logic        fire;
    logic [3:0]  p_kind;
    logic        is_punct, is_ws, is_nl, is_other;
    logic        closes;
    logic        hit_return, hit_if, hit_else;
    logic [3:0]  word_kind;
    logic [11:0] col_inc;
    logic [11:0] base_len;
    klex_tok_t   word_tok, punct_tok;

    assign fire         = s1_valid_reg && room;
    assign chars.ready  = !s1_valid_reg || room;
    assign accept       = chars.valid && chars.ready;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        hit_return = (word_len_reg == 12'd6);
        for (int i = 0; i < 6; i++)
        begin
            if (kw_bytes_reg[i] != KW_RETURN_TEXT[i])
            begin
                hit_return = 1'b0;
            end
        end
        hit_if = (word_len_reg == 12'd2);
        for (int i = 0; i < 2; i++)
        begin
            if (kw_bytes_reg[i] != KW_IF_TEXT[i])
            begin
                hit_if = 1'b0;
            end
        end
        hit_else = (word_len_reg == 12'd4);
        for (int i = 0; i < 4; i++)
        begin
            if (kw_bytes_reg[i] != KW_ELSE_TEXT[i])
            begin
                hit_else = 1'b0;
            end
        end
        priority if (hit_return)
        begin
            word_kind = KIND_RETURN;
        end
        else if (hit_if)
        begin
            word_kind = KIND_IF;
        end
        else if (hit_else)
        begin
            word_kind = KIND_ELSE;
        end
        else
        begin
            word_kind = KIND_WORD;
        end
    end

    always_comb
    begin
        p_kind   = punct_kind(ch_reg);
        is_punct = !eoi_reg && (p_kind != KIND_WORD);
        is_ws    = !eoi_reg && ((ch_reg == CH_SPACE) || (ch_reg == CH_TAB));
        is_nl    = !eoi_reg && (ch_reg == CH_NEWLINE);
        is_other = !eoi_reg && !is_punct && !is_ws && !is_nl;
        closes   = in_word_reg && !is_other;
        col_inc  = (column_reg < COL_CAP) ? column_reg + 12'd1 : column_reg;
        base_len = in_word_reg ? word_len_reg : 12'd0;

        word_tok.kind      = word_kind;
        word_tok.line      = line_reg;
        word_tok.start_col = word_start_reg;
        word_tok.end_col   = column_reg;
        word_tok.last      = !is_punct;

        punct_tok.kind      = p_kind;
        punct_tok.line      = line_reg;
        punct_tok.start_col = 12'd0;
        punct_tok.end_col   = 12'd0;
        punct_tok.last      = 1'b1;

        push.first  = closes ? word_tok : punct_tok;
        push.second = punct_tok;
        push.count  = fire ? (2'(closes) + 2'(is_punct)) : 2'd0;

        in_word_next    = in_word_reg;
        word_start_next = word_start_reg;
        word_len_next   = word_len_reg;
        column_next     = column_reg;
        line_next       = line_reg;
        for (int i = 0; i < KEYWORD_MAX; i++)
        begin
            kw_bytes_next[i] = kw_bytes_reg[i];
        end

        if (fire)
        begin
            if (closes)
            begin
                in_word_next = 1'b0;
            end
            if (is_punct || is_ws)
            begin
                column_next = col_inc;
            end
            if (is_nl)
            begin
                column_next = 12'd0;
                line_next   = (line_reg < LINE_CAP) ? line_reg + 16'd1 : line_reg;
            end
            if (is_other)
            begin
                // Open a fresh word with a cleared prefix, or extend the open one
                in_word_next = 1'b1;
                if (!in_word_reg)
                begin
                    word_start_next = column_reg;
                    for (int i = 0; i < KEYWORD_MAX; i++)
                    begin
                        kw_bytes_next[i] = 8'h00;
                    end
                end
                if (base_len < 12'(KEYWORD_MAX))
                begin
                    kw_bytes_next[base_len[KW_IDX_W-1:0]] = ch_reg;
                end
                word_len_next = (base_len < LEN_CAP) ? base_len + 12'd1 : base_len;
                column_next   = col_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            in_word_reg  <= 1'b0;
            column_reg   <= 12'd0;
            line_reg     <= 16'd1;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            in_word_reg  <= in_word_next;
            column_reg   <= column_next;
            line_reg     <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= chars.ch;
            eoi_reg <= chars.end_of_input;
        end
        word_start_reg <= word_start_next;
        word_len_reg   <= word_len_next;
        for (int i = 0; i < KEYWORD_MAX; i++)
        begin
            kw_bytes_reg[i] <= kw_bytes_next[i];
        end
    end

endmodule

FILE: design/klex_outq.sv
module klex_outq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  klex_pkg::klex_push_t                push,
    output logic                                room,
    output logic [klex_pkg::QUEUE_CNT_W-1:0]    level,
    klex_out_if.source                          tokens
);
    import klex_pkg::*;

    klex_tok_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                     pop;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_inc;
    klex_tok_t                head;

    assign head       = mem_reg[rd_ptr_reg];
    assign pop        = tokens.valid && tokens.ready;
    assign wr_ptr_inc = wr_ptr_reg + QUEUE_PTR_W'(1);

    // Room for a full pair, regardless of this cycle's pop
    assign room  = count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
    assign level = count_reg;

    assign tokens.valid        = count_reg != '0;
    assign tokens.token_kind   = head.kind;
    assign tokens.line_number  = head.line;
    assign tokens.start_column = head.start_col;
    assign tokens.end_column   = head.end_col;
    assign tokens.last         = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
        count_next  = count_reg + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.second;
        end
    end

endmodule

FILE: test/token_checker.sv
`timescale 1ns / 100ps
module token_checker (
    input  logic clk,
    input  logic rst_n,
    klex_in_if   chars,
    klex_out_if  tokens,
    output int   failures,
    output int   pending
);
    import klex_pkg::*;

    localparam int PREFIX_BYTES = KEYWORD_MAX_DEF;

    // Punctuation bytes in token-kind order, starting at KIND_SEMI
    localparam logic [7:0] PUNCT_BYTES [12] = '{CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACE,
                                                CH_RBRACE, CH_PLUS, CH_MINUS, CH_SLASH,
                                                CH_STAR, CH_EQUAL, CH_QUOTE, CH_COMMA};

    localparam logic [47:0] SPELL_RETURN = "return";
    localparam logic [31:0] SPELL_ELSE   = "else";
    localparam logic [15:0] SPELL_IF     = "if";

    logic                      word_open;
    logic [11:0]               word_start;
    logic [11:0]               word_len;
    logic [11:0]               column;
    logic [15:0]               line_no;
    logic [8*PREFIX_BYTES-1:0] word_prefix;   // first byte of the word in the top byte
    klex_tok_t                 expected_tokens [$];
    int                        fail_count;

    function automatic logic [3:0] word_kind();
        logic [47:0] head;
        head = word_prefix[8*PREFIX_BYTES-1 -: 48];
        if (word_len == 12'd6 && head == SPELL_RETURN)
            return KIND_RETURN;
        if (word_len == 12'd2 && head[47:32] == SPELL_IF)
            return KIND_IF;
        if (word_len == 12'd4 && head[47:16] == SPELL_ELSE)
            return KIND_ELSE;
        return KIND_WORD;
    endfunction

    // Advance the lexer state by one request and queue the tokens it yields
    function automatic void lex_char(input logic [7:0] c, input logic flush);
        klex_tok_t  made [2];
        int         n;
        logic [3:0] punct;
        logic       separator;
        n = 0;
        punct = KIND_WORD;
        for (int i = 0; i < 12; i++)
            if (!flush && c == PUNCT_BYTES[i])
                punct = KIND_SEMI + 4'(i);
        separator = flush || punct != KIND_WORD || c == CH_SPACE || c == CH_TAB
                    || c == CH_NEWLINE;

        if (separator && word_open)
        begin
            made[n] = '{kind: word_kind(), line: line_no, start_col: word_start,
                        end_col: column, last: 1'b0};
            n++;
            word_open = 1'b0;
        end
        if (punct != KIND_WORD)
        begin
            made[n] = '{kind: punct, line: line_no, start_col: '0, end_col: '0, last: 1'b0};
            n++;
        end

        if (!flush && c == CH_NEWLINE)
        begin
            column = '0;
            if (line_no < LINE_CAP)
                line_no++;
        end
        else if (!flush)
        begin
            if (!separator)
            begin
                if (!word_open)
                begin
                    word_open   = 1'b1;
                    word_start  = column;
                    word_len    = '0;
                    word_prefix = '0;
                end
                if (word_len < 12'(PREFIX_BYTES))
                    word_prefix[8 * (PREFIX_BYTES - 1 - int'(word_len)) +: 8] = c;
                if (word_len < LEN_CAP)
                    word_len++;
            end
            if (column < COL_CAP)
                column++;
        end

        for (int i = 0; i < n; i++)
        begin
            made[i].last = (i == n - 1);
            expected_tokens.push_back(made[i]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        klex_tok_t want;
        if (!rst_n)
        begin
            word_open   = 1'b0;
            word_start  = '0;
            word_len    = '0;
            word_prefix = '0;
            column      = '0;
            line_no     = 16'd1;
            fail_count  = 0;
            expected_tokens.delete();
        end
        else
        begin
            if (tokens.valid && tokens.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected token: expected none, got kind=%0d line=%0d",
                             $time, tokens.token_kind, tokens.line_number,
                             " start=%0d end=%0d last=%0b",
                             tokens.start_column, tokens.end_column, tokens.last);
                end
                else
                begin
                    want = expected_tokens[0];
                    expected_tokens.delete(0);
                    if (tokens.token_kind !== want.kind || tokens.line_number !== want.line
                        || tokens.start_column !== want.start_col
                        || tokens.end_column !== want.end_col || tokens.last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t token mismatch: expected kind=%0d line=%0d start=%0d",
                                 $time, want.kind, want.line, want.start_col,
                                 " end=%0d last=%0b, got kind=%0d line=%0d start=%0d",
                                 want.end_col, want.last, tokens.token_kind,
                                 tokens.line_number, tokens.start_column,
                                 " end=%0d last=%0b", tokens.end_column, tokens.last);
                    end
                end
            end
            if (chars.valid && chars.ready)
                lex_char(chars.ch, chars.end_of_input);
        end
        failures <= fail_count;
        pending  <= expected_tokens.size();
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
module tb;
    import klex_pkg::*;

    // Run limits. Some 450 requests; even with two tokens each, heavy idling on
    // both sides and the long hold-off, a run stays well under CYCLE_LIMIT.
    localparam int CYCLE_LIMIT    = 20000;
    localparam int RANDOM_ITEMS   = 360;
    localparam int HOLD_CYCLES    = 120;
    localparam int HOLD_PAIRS     = 24;
    localparam int DRAIN_CYCLES   = 10;

    localparam logic [7:0] PUNCT_BYTES [12] = '{CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACE,
                                                CH_RBRACE, CH_PLUS, CH_MINUS, CH_SLASH,
                                                CH_STAR, CH_EQUAL, CH_QUOTE, CH_COMMA};
    localparam logic [7:0] LETTER_LO = "a";
    localparam logic [7:0] LETTER_HI = "z";

    // Keywords and their near misses: one byte short, one byte long, wrong case
    string near_keywords [10] = '{"return", "if", "else", "retur", "returns",
                                  "iff", "i", "els", "elsee", "Return"};

    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_requests = 0;
    int   holds_served  = 0;
    int   requests_sent = 0;
    int   cycle_count;

    klex_in_if  chars_if ();
    klex_out_if tokens_if ();

    keyword_lexer_step uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    token_checker token_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars_if),
        .tokens   (tokens_if),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one request, idling first at the current sender rate, and hold it
    // until the block takes it. Valid stays high between back-to-back requests.
    task automatic send_char(input logic [7:0] c, input logic flush);
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid        <= 1'b1;
        chars_if.ch           <= c;
        chars_if.end_of_input <= flush;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    task automatic send_letters(input int len);
        for (int i = 0; i < len; i++)
            send_char(8'($urandom_range(LETTER_HI, LETTER_LO)), 1'b0);
    endtask

    // One piece of random source text. Most pieces look like real code
    // (keywords, identifiers, punctuation, blanks, line ends); the rest are
    // flushes with a junk byte beside them and raw bytes of any value.
    task automatic send_piece();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            send_text(near_keywords[$urandom_range(9)]);
        else if (pick < 40)
            send_letters($urandom_range(9, 1));
        else if (pick < 60)
            send_char(PUNCT_BYTES[$urandom_range(11)], 1'b0);
        else if (pick < 72)
            send_char($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
        else if (pick < 82)
            send_char(CH_NEWLINE, 1'b0);
        else if (pick < 88)
            send_char(8'($urandom), 1'b1);
        else
            send_char(8'($urandom), 1'b0);
    endtask

    // Token side. Drop ready at the current receiver rate; when the stimulus
    // asks for a hold-off, keep ready low for a long count of our own so the
    // result queue fills and the block stalls the chars side.
    initial
    begin
        tokens_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                tokens_if.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                holds_served++;
            end
            else
                tokens_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a run that reaches the limit has hung.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n                 <= 1'b0;
        chars_if.valid        <= 1'b0;
        chars_if.ch           <= '0;
        chars_if.end_of_input <= 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 48;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each keyword closed by punctuation (word then punctuation,
        // last only on the second), a tab after punctuation, the remaining
        // punctuation bytes, a word of the extreme byte values flushed by end
        // of input with a junk byte beside the flag, then a line end.
        send_text("if(\t");
        send_text("else{");
        send_text("return;");
        send_text(")}+-/*=\",");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(CH_NEWLINE, 1'b0);

        // Random text in three idle regimes: receiver-bound, sender-bound,
        // then both sides at full rate.
        for (int phase = 0; phase < 3; phase++)
        begin
            int goal;
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 48 : 0;
            recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 18 : 0;
            goal = requests_sent + RANDOM_ITEMS / 3;
            while (requests_sent < goal)
                send_piece();
        end

        // Back pressure: hold the token side off while words closed by
        // punctuation keep arriving, two tokens per pair of requests.
        hold_requests++;
        for (int i = 0; i < HOLD_PAIRS; i++)
            send_text("x;");

        // Tail: a keyword closed by punctuation, then one flushed by end of input.
        send_text("else;");
        send_text("return");
        send_char(8'h00, 1'b1);

        chars_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // Give a stray extra token time to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: keyword_lexer_step.f
design/klex_pkg.sv
design/klex_if.sv
design/klex_scan.sv
design/klex_outq.sv
design/keyword_lexer_step.sv
test/token_checker.sv
test/tb.sv
